/* design/multichannel_echo_ranger_unit_assert.svh */
// Assertion macros for the echo ranger unit.
`ifndef MULTICHANNEL_ECHO_RANGER_UNIT_ASSERT_SVH
`define MULTICHANNEL_ECHO_RANGER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MCER_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCER_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mcer_pkg.sv */
// Shared types, constants and codes of the echo ranger unit.
package mcer_pkg;

   localparam int CHANNELS_DEF    = 15;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int CHAN_W    = 4;
   localparam int COUNT_W   = 16;
   localparam int LEVELS_W  = 15;
   localparam int LEVELS_EXT_W = 16;
   localparam int SECONDS_W = 16;
   localparam int DIST_W    = 14;
   localparam int SAMPLES_W = 8;
   localparam int KIND_W    = 2;
   localparam int MAX_REPORTS = 15;

   // distance = width * 34 / 100 / 2, done as one multiply by a scaled reciprocal
   localparam int DIST_NUM    = 34;
   localparam int DIST_DEN    = 100 * 2;
   localparam int DIST_SHIFT  = 29;
   localparam int DIST_RECIP  = ((1 << DIST_SHIFT) + DIST_DEN - 1) / DIST_DEN;
   localparam int DIST_MULT_W = 27;
   localparam logic [DIST_MULT_W-1:0] DIST_MULT = DIST_MULT_W'(DIST_NUM * DIST_RECIP);
   localparam int PROD_W      = COUNT_W + DIST_MULT_W;

   localparam logic [KIND_W-1:0] KIND_ECHO     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PERIOD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TRIG_END = 2'd2;

   typedef enum logic [1:0] {
      CMD_ECHO,
      CMD_PERIOD,
      CMD_TRIG_END,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [CHAN_W-1:0]     channel;
      logic                  level;
      logic [COUNT_W-1:0]    counter;
      logic [LEVELS_W-1:0]   levels;
      logic [SECONDS_W-1:0]  seconds;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_SWEEP,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      logic                  valid;
      logic                  report;
      logic [CHAN_W-1:0]     channel;
      logic [DIST_W-1:0]     distance;
      logic                  last;
      logic                  trigger;
      logic [SAMPLES_W-1:0]  samples;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic sweep_end;
   } back_stat_type;

endpackage

/* design/multichannel_echo_ranger_unit.sv */
// Top level of the multichannel ultrasonic echo ranger.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | req_tuser kind, req_tdata event fields
//   rsp     | out | rsp_tvalid/rsp_tready  | rsp_tuser report flag, rsp_tdata, rsp_tlast
//
// An echo edge passes the sequencer's take and execute states, the width stage and the
// output register; a trigger end or an unknown kind also passes a status state. A period
// start is taken and executed, then the single sweep over the width registers offers one
// report a cycle while the output does not stall, for each reported channel (up to
// fifteen). The front register and a two-entry command queue keep taking requests while
// the back part works, until the queue fills. Reset is synchronous and active high; it
// clears all channel state, the queue and both output stages. A stalled rsp_tready holds
// the output register, then the width stage, then the sequencer, then the queue.
`include "multichannel_echo_ranger_unit_assert.svh"

module multichannel_echo_ranger_unit #(
   parameter int CHANNELS    = mcer_pkg::CHANNELS_DEF,
   parameter int QUEUE_DEPTH = mcer_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic [55:0] req_tdata,   // channel[3:0], echo_level[4], counter_us[20:5],
                                    // echo_levels[35:21], seconds_now[51:36], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // [0] report_valid
   output logic [31:0] rsp_tdata,   // report_channel[3:0], distance[17:4],
                                    // trigger_level[18], samples_last_second[26:19]
   output logic        rsp_tlast
);

   localparam int REPORTS = (CHANNELS < mcer_pkg::MAX_REPORTS) ? CHANNELS
                                                               : mcer_pkg::MAX_REPORTS;

   logic                    fq_valid, fq_ready;
   mcer_pkg::cmd_type       fq_cmd;
   logic                    qb_valid, qb_ready;
   mcer_pkg::cmd_type       qb_cmd;
   mcer_pkg::rsp_type       rsp;
   mcer_pkg::back_stat_type bk_stat;

   // classify each request into a command
   mcer_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_channel (req_tdata[3:0]),
      .req_level   (req_tdata[4]),
      .req_counter (req_tdata[20:5]),
      .req_levels  (req_tdata[35:21]),
      .req_seconds (req_tdata[51:36]),
      .cmd_valid   (fq_valid),
      .cmd_ready   (fq_ready),
      .cmd         (fq_cmd)
   );

   // decouple the front from the back sequencer
   mcer_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   // carry out commands against the channel state and produce results
   mcer_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd       (qb_cmd),
      .rsp       (rsp),
      .rsp_ready (rsp_tready),
      .stat      (bk_stat)
   );

   // pack the result fields, lowest bit first
   assign rsp_tvalid   = rsp.valid;
   assign rsp_tuser[0] = rsp.report;
   assign rsp_tlast    = rsp.last;
   assign rsp_tdata    = {5'd0, rsp.samples, rsp.trigger, rsp.distance, rsp.channel};

   // status results carry neither channel nor distance
   `MCER_ASSERT_NOW(a_status_empty, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[17:0] == 18'd0, "status result carries data")
   // a status result always closes its request
   `MCER_ASSERT_NOW(a_status_last, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast, "status result without last")
   // reports only name channels that are reported
   `MCER_ASSERT_NOW(a_report_chan, clock, reset, rsp_tvalid && rsp_tuser[0], {1'b0, rsp_tdata[3:0]} < 5'(REPORTS), "report on an unreported channel")
   // the sequencer returns to idle after the final sweep step
   `MCER_ASSERT_NEXT(a_sweep_done, clock, reset, bk_stat.sweep_end, !bk_stat.busy, "sweep did not finish")

endmodule

/* design/mcer_front.sv */
// Front part: accepts requests and classifies them into commands.
module mcer_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mcer_pkg::KIND_W-1:0]   req_kind,
   input  logic [mcer_pkg::CHAN_W-1:0]   req_channel,
   input  logic                          req_level,
   input  logic [mcer_pkg::COUNT_W-1:0]  req_counter,
   input  logic [mcer_pkg::LEVELS_W-1:0] req_levels,
   input  logic [mcer_pkg::SECONDS_W-1:0] req_seconds,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output mcer_pkg::cmd_type             cmd
);

   logic                 valid_ff, valid_in;
   mcer_pkg::cmd_type    cmd_ff, cmd_in;
   mcer_pkg::cmd_kind_type kind_dec;
   logic                 accept;

   assign req_ready = !valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      case (req_kind)
         mcer_pkg::KIND_ECHO:     kind_dec = mcer_pkg::CMD_ECHO;
         mcer_pkg::KIND_PERIOD:   kind_dec = mcer_pkg::CMD_PERIOD;
         mcer_pkg::KIND_TRIG_END: kind_dec = mcer_pkg::CMD_TRIG_END;
         default:                 kind_dec = mcer_pkg::CMD_NOP;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in       = 1'b1;
         cmd_in.kind    = kind_dec;
         cmd_in.channel = req_channel;
         cmd_in.level   = req_level;
         cmd_in.counter = req_counter;
         cmd_in.levels  = req_levels;
         cmd_in.seconds = req_seconds;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

/* design/mcer_queue.sv */
// Short command queue between the front and back parts.
module mcer_queue #(
   parameter int DEPTH = mcer_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mcer_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mcer_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mcer_pkg::cmd_type  store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;
   assign pop_cmd    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/mcer_back.sv */
// Back part: channel state, command sequencer, distance stage and output register.
module mcer_back #(
   parameter int CHANNELS = mcer_pkg::CHANNELS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  mcer_pkg::cmd_type       cmd,
   output mcer_pkg::rsp_type       rsp,
   input  logic                    rsp_ready,
   output mcer_pkg::back_stat_type stat
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int REPORTS = (CHANNELS < mcer_pkg::MAX_REPORTS) ? CHANNELS
                                                               : mcer_pkg::MAX_REPORTS;
   localparam int CW      = mcer_pkg::COUNT_W;

   mcer_pkg::back_state_type state_ff, state_in;
   mcer_pkg::cmd_type        cmd_ff, cmd_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;

   logic                     held_ff [CHANNELS];
   logic                     held_in [CHANNELS];
   logic [CW-1:0]            rise_ff [CHANNELS];
   logic [CW-1:0]            rise_in [CHANNELS];
   logic [CW-1:0]            width_ff [CHANNELS];
   logic [CW-1:0]            width_in [CHANNELS];
   logic                     trig_ff, trig_in;
   logic [mcer_pkg::SECONDS_W-1:0] last_sec_ff, last_sec_in;
   logic [mcer_pkg::SAMPLES_W-1:0] last_cnt_ff, last_cnt_in;
   logic [mcer_pkg::SAMPLES_W-1:0] per_cnt_ff, per_cnt_in;

   // width stage ahead of the multiplier
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_report_ff, s2_report_in;
   logic [mcer_pkg::CHAN_W-1:0] s2_chan_ff, s2_chan_in;
   logic                     s2_last_ff, s2_last_in;
   logic                     s2_trig_ff, s2_trig_in;
   logic [mcer_pkg::SAMPLES_W-1:0] s2_cnt_ff, s2_cnt_in;
   logic [CW-1:0]            s2_width_ff, s2_width_in;

   mcer_pkg::rsp_type        out_ff, out_in;

   logic                     out_free, s2_move, s2_free;
   logic [IDX_W-1:0]         ch_idx;
   logic                     in_range;
   logic [CW-1:0]            cur_rise;
   logic [mcer_pkg::LEVELS_EXT_W-1:0] levels_ext;
   logic [mcer_pkg::PROD_W-1:0] prod;
   logic                     sweep_end;

   assign out_free = !out_ff.valid || rsp_ready;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;

   assign ch_idx     = cmd_ff.channel[IDX_W-1:0];
   assign in_range   = {1'b0, cmd_ff.channel} < (mcer_pkg::CHAN_W + 1)'(CHANNELS);
   assign cur_rise   = rise_ff[ch_idx];
   assign levels_ext = {1'b0, cmd_ff.levels};

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      held_in     = held_ff;
      rise_in     = rise_ff;
      width_in    = width_ff;
      trig_in     = trig_ff;
      last_sec_in = last_sec_ff;
      last_cnt_in = last_cnt_ff;
      per_cnt_in  = per_cnt_ff;
      cmd_ready   = 1'b0;
      sweep_end   = 1'b0;

      s2_valid_in  = s2_move ? 1'b0 : s2_valid_ff;
      s2_report_in = s2_report_ff;
      s2_chan_in   = s2_chan_ff;
      s2_last_in   = s2_last_ff;
      s2_trig_in   = s2_trig_ff;
      s2_cnt_in    = s2_cnt_ff;
      s2_width_in  = s2_width_ff;

      case (state_ff)
         mcer_pkg::BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = mcer_pkg::BK_EXEC;
            end
         end
         mcer_pkg::BK_EXEC: begin
            case (cmd_ff.kind)
               mcer_pkg::CMD_ECHO: begin
                  // update and emit together, so wait for room first
                  if (s2_free) begin
                     s2_valid_in  = 1'b1;
                     s2_report_in = 1'b0;
                     s2_chan_in   = '0;
                     s2_last_in   = 1'b1;
                     s2_trig_in   = trig_ff;
                     s2_cnt_in    = last_cnt_ff;
                     s2_width_in  = '0;
                     if (in_range && held_ff[ch_idx] != cmd_ff.level) begin
                        held_in[ch_idx] = cmd_ff.level;
                        if (cmd_ff.level && cur_rise == '0) begin
                           rise_in[ch_idx] = cmd_ff.counter;
                        end else if (!cmd_ff.level && cur_rise != '0) begin
                           // fall not after rise keeps the old width but still reports
                           if (cur_rise < cmd_ff.counter) begin
                              width_in[ch_idx] = cmd_ff.counter - cur_rise;
                              s2_width_in      = cmd_ff.counter - cur_rise;
                           end else begin
                              s2_width_in      = width_ff[ch_idx];
                           end
                           s2_report_in = 1'b1;
                           s2_chan_in   = cmd_ff.channel;
                        end
                     end
                     state_in = mcer_pkg::BK_IDLE;
                  end
               end
               mcer_pkg::CMD_PERIOD: begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     rise_in[i] = '0;
                     held_in[i] = levels_ext[i];
                     if (i >= REPORTS) begin
                        width_in[i] = '0;
                     end
                  end
                  trig_in = 1'b1;
                  if (last_sec_ff != cmd_ff.seconds) begin
                     last_sec_in = cmd_ff.seconds;
                     last_cnt_in = per_cnt_ff;
                     per_cnt_in  = 8'd1;
                  end else begin
                     per_cnt_in  = per_cnt_ff + 8'd1;
                  end
                  idx_in   = '0;
                  state_in = mcer_pkg::BK_SWEEP;
               end
               mcer_pkg::CMD_TRIG_END: begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     rise_in[i] = '0;
                  end
                  trig_in  = 1'b0;
                  state_in = mcer_pkg::BK_STATUS;
               end
               default: begin
                  state_in = mcer_pkg::BK_STATUS;
               end
            endcase
         end
         mcer_pkg::BK_SWEEP: begin
            // report the old width of each reported channel, clearing it as it goes
            if (s2_free) begin
               s2_valid_in      = 1'b1;
               s2_report_in     = 1'b1;
               s2_chan_in       = mcer_pkg::CHAN_W'(idx_ff);
               s2_last_in       = idx_ff == IDX_W'(REPORTS - 1);
               s2_trig_in       = trig_ff;
               s2_cnt_in        = last_cnt_ff;
               s2_width_in      = width_ff[idx_ff];
               width_in[idx_ff] = '0;
               if (idx_ff == IDX_W'(REPORTS - 1)) begin
                  sweep_end = 1'b1;
                  state_in  = mcer_pkg::BK_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         mcer_pkg::BK_STATUS: begin
            if (s2_free) begin
               s2_valid_in  = 1'b1;
               s2_report_in = 1'b0;
               s2_chan_in   = '0;
               s2_last_in   = 1'b1;
               s2_trig_in   = trig_ff;
               s2_cnt_in    = last_cnt_ff;
               s2_width_in  = '0;
               state_in     = mcer_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mcer_pkg::BK_IDLE;
         end
      endcase
   end

   assign prod = mcer_pkg::PROD_W'(s2_width_ff) * mcer_pkg::PROD_W'(mcer_pkg::DIST_MULT);

   always_comb begin
      out_in = out_ff;
      if (out_free) begin
         out_in.valid = s2_valid_ff;
         if (s2_valid_ff) begin
            out_in.report   = s2_report_ff;
            out_in.channel  = s2_chan_ff;
            out_in.distance = s2_report_ff ?
                              prod[mcer_pkg::DIST_SHIFT +: mcer_pkg::DIST_W] : '0;
            out_in.last     = s2_last_ff;
            out_in.trigger  = s2_trig_ff;
            out_in.samples  = s2_cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mcer_pkg::BK_IDLE;
         idx_ff      <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            held_ff[i]  <= 1'b0;
            rise_ff[i]  <= '0;
            width_ff[i] <= '0;
         end
         trig_ff     <= 1'b0;
         last_sec_ff <= '1;
         last_cnt_ff <= '0;
         per_cnt_ff  <= '0;
         s2_valid_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         held_ff     <= held_in;
         rise_ff     <= rise_in;
         width_ff    <= width_in;
         trig_ff     <= trig_in;
         last_sec_ff <= last_sec_in;
         last_cnt_ff <= last_cnt_in;
         per_cnt_ff  <= per_cnt_in;
         s2_valid_ff <= s2_valid_in;
         out_ff.valid <= out_in.valid;
      end
      cmd_ff          <= cmd_in;
      s2_report_ff    <= s2_report_in;
      s2_chan_ff      <= s2_chan_in;
      s2_last_ff      <= s2_last_in;
      s2_trig_ff      <= s2_trig_in;
      s2_cnt_ff       <= s2_cnt_in;
      s2_width_ff     <= s2_width_in;
      out_ff.report   <= out_in.report;
      out_ff.channel  <= out_in.channel;
      out_ff.distance <= out_in.distance;
      out_ff.last     <= out_in.last;
      out_ff.trigger  <= out_in.trigger;
      out_ff.samples  <= out_in.samples;
   end

   assign rsp            = out_ff;
   assign stat.busy      = state_ff != mcer_pkg::BK_IDLE;
   assign stat.sweep_end = sweep_end;

endmodule
